>>> sv/oes_pkg.sv
// Shared types and constants for the obstacle escape sequencer.
// Used by obstacle_escape_sequencer_core; depends on nothing else.
package oes_pkg;

    // Sample and timer widths
    localparam int DIST_W     = 8;
    localparam int TIMER_BITS = 16;
    localparam int LEN_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_CM    = 8'd0,
        REG_CLEAR_CM   = 8'd1,
        REG_TURN_TICKS = 8'd2,
        REG_RUN_TICKS  = 8'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [DIST_W-1:0] NEAR_RST  = DIST_W'(30);
    localparam logic [DIST_W-1:0] CLEAR_RST = DIST_W'(40);
    localparam logic [LEN_W-1:0]  TURN_RST  = LEN_W'(300);
    localparam logic [LEN_W-1:0]  RUN_RST   = LEN_W'(1000);

    // Drive commands
    typedef enum logic [1:0] {
        CMD_FWD   = 2'd0,
        CMD_BWD   = 2'd1,
        CMD_RIGHT = 2'd2,
        CMD_LEFT  = 2'd3
    } motor_cmd_t;

    // Stream widths, padded to whole bytes
    localparam int S_DATA_W = 2 * DIST_W;
    localparam int M_DATA_W = 8;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    // Phase length to loaded count: zero acts as one, saturates at timer max
    function automatic logic [TIMER_BITS-1:0] load_count(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] c;
        logic [32:0]      c_ext;
        c     = (len == '0) ? '0 : len - LEN_W'(1);
        c_ext = 33'(c);
        if (c_ext > TIMER_MAX)
        begin
            return TIMER_MAX[TIMER_BITS-1:0];
        end
        return c_ext[TIMER_BITS-1:0];
    endfunction

endpackage

>>> sv/obstacle_escape_sequencer_core.sv
// Obstacle escape sequencer: tick-driven phase machine with config registers.
// Depends on oes_pkg.
//
// Usage:
//   s_axis carries one beat per millisecond tick: front and rear distance
//   samples. m_axis returns exactly one beat per input beat: drive command
//   and the two escape LEDs. cfg_* writes the four threshold and length
//   registers (index 0..3, higher indexes ignored); cfg_ready is always high
//   and writes are meant to happen only while the block is idle.
// Pipeline and throughput:
//   A beat is held in the input register, then the phase machine
//   updates and the result lands in the output register. One beat per
//   cycle is sustained while m_axis_tready stays high; the single pass of
//   phase logic between the input and output registers sets this.
// Reset:
//   rst_n clears both stages, loads register defaults (30, 40, 300, 1000)
//   and returns to cruising forward with the timer at zero.
// Stalls:
//   When m_axis_tready is low the result holds; the input register still
//   takes one more beat, then s_axis_tready drops until the result drains.
module obstacle_escape_sequencer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream: [7:0] front_cm, [15:8] rear_cm
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [oes_pkg::S_DATA_W-1:0]        s_axis_tdata,
    // Output stream: [1:0] motor_cmd, [2] led_front, [3] led_rear, [7:4] zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [oes_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [oes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [oes_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        PH_CRUISE   = 2'd0,
        PH_TURN     = 2'd1,
        PH_RUN      = 2'd2,
        PH_BACKTURN = 2'd3
    } phase_t;

    // Configuration registers
    logic [oes_pkg::DIST_W-1:0]     near_cm_reg;
    logic [oes_pkg::DIST_W-1:0]     clear_cm_reg;
    logic [oes_pkg::LEN_W-1:0]      turn_ticks_reg;
    logic [oes_pkg::LEN_W-1:0]      run_ticks_reg;

    // Input stage
    logic                           in_valid_reg;
    logic [oes_pkg::DIST_W-1:0]     front_reg;
    logic [oes_pkg::DIST_W-1:0]     rear_reg;

    // Machine state
    phase_t                         phase_reg, phase_next;
    logic                           heading_reg, heading_next;
    logic                           origin_reg, origin_next;
    logic [oes_pkg::TIMER_BITS-1:0] timer_reg, timer_next;

    // Output stage
    logic                           out_valid_reg;
    oes_pkg::motor_cmd_t            cmd_reg, cmd_next;
    logic                           led_front_reg, led_front_next;
    logic                           led_rear_reg, led_rear_next;

    logic                           advance;
    logic                           in_take;
    logic [oes_pkg::DIST_W-1:0]     ahead, own_side, other_side;
    logic [oes_pkg::TIMER_BITS-1:0] turn_load, run_load;
    oes_pkg::motor_cmd_t            heading_cmd, first_turn_cmd, back_turn_cmd;

    // Handshake: input stage moves on when the output register is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, led_rear_reg, led_front_reg, cmd_reg};

    // Side selection and phase lengths
    assign ahead          = heading_reg ? rear_reg : front_reg;
    assign own_side       = origin_reg ? rear_reg : front_reg;
    assign other_side     = origin_reg ? front_reg : rear_reg;
    assign turn_load      = oes_pkg::load_count(turn_ticks_reg);
    assign run_load       = oes_pkg::load_count(run_ticks_reg);
    assign heading_cmd    = heading_reg ? oes_pkg::CMD_BWD : oes_pkg::CMD_FWD;
    assign first_turn_cmd = origin_reg ? oes_pkg::CMD_LEFT : oes_pkg::CMD_RIGHT;
    assign back_turn_cmd  = heading_reg ? oes_pkg::CMD_RIGHT : oes_pkg::CMD_LEFT;

    // Phase machine, one tick per pass
    always_comb
    begin
        phase_next   = phase_reg;
        heading_next = heading_reg;
        origin_next  = origin_reg;
        timer_next   = timer_reg;
        cmd_next     = heading_cmd;
        unique case (phase_reg)
            PH_CRUISE:
            begin
                if (ahead < near_cm_reg)
                begin
                    origin_next = heading_reg;
                    phase_next  = PH_TURN;
                    timer_next  = turn_load;
                    cmd_next    = heading_reg ? oes_pkg::CMD_LEFT : oes_pkg::CMD_RIGHT;
                end
            end
            PH_TURN:
            begin
                if (timer_reg != '0)
                begin
                    timer_next = timer_reg - 1'b1;
                    cmd_next   = first_turn_cmd;
                end
                else if (own_side > clear_cm_reg || other_side > clear_cm_reg)
                begin
                    // origin side wins when both are clear
                    heading_next = (own_side > clear_cm_reg) ? origin_reg : !origin_reg;
                    phase_next   = PH_RUN;
                    timer_next   = run_load;
                    cmd_next     = heading_next ? oes_pkg::CMD_BWD : oes_pkg::CMD_FWD;
                end
                else
                begin
                    // neither side clear: turn again
                    timer_next = turn_load;
                    cmd_next   = first_turn_cmd;
                end
            end
            PH_RUN:
            begin
                if (timer_reg != '0)
                begin
                    timer_next = timer_reg - 1'b1;
                end
                else
                begin
                    phase_next = PH_BACKTURN;
                    timer_next = turn_load;
                    cmd_next   = back_turn_cmd;
                end
            end
            PH_BACKTURN:
            begin
                if (timer_reg != '0)
                begin
                    timer_next = timer_reg - 1'b1;
                    cmd_next   = back_turn_cmd;
                end
                else
                begin
                    phase_next = PH_CRUISE;
                    timer_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_CRUISE;
            end
        endcase
        led_front_next = (phase_next != PH_CRUISE) && !origin_next;
        led_rear_next  = (phase_next != PH_CRUISE) && origin_next;
    end

    // State, config and stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_cm_reg    <= oes_pkg::NEAR_RST;
            clear_cm_reg   <= oes_pkg::CLEAR_RST;
            turn_ticks_reg <= oes_pkg::TURN_RST;
            run_ticks_reg  <= oes_pkg::RUN_RST;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_CRUISE;
            heading_reg    <= 1'b0;
            origin_reg     <= 1'b0;
            timer_reg      <= '0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    oes_pkg::REG_NEAR_CM:    near_cm_reg    <= cfg_data[oes_pkg::DIST_W-1:0];
                    oes_pkg::REG_CLEAR_CM:   clear_cm_reg   <= cfg_data[oes_pkg::DIST_W-1:0];
                    oes_pkg::REG_TURN_TICKS: turn_ticks_reg <= cfg_data[oes_pkg::LEN_W-1:0];
                    oes_pkg::REG_RUN_TICKS:  run_ticks_reg  <= cfg_data[oes_pkg::LEN_W-1:0];
                    default:                 ;
                endcase
            end

            // input stage
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            // state update and output stage
            if (advance)
            begin
                phase_reg     <= phase_next;
                heading_reg   <= heading_next;
                origin_reg    <= origin_next;
                timer_reg     <= timer_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            front_reg <= s_axis_tdata[oes_pkg::DIST_W-1:0];
            rear_reg  <= s_axis_tdata[oes_pkg::S_DATA_W-1:oes_pkg::DIST_W];
        end
        if (advance)
        begin
            cmd_reg       <= cmd_next;
            led_front_reg <= led_front_next;
            led_rear_reg  <= led_rear_next;
        end
    end

`ifndef ASSERT_OFF
    // Only one escape LED can be lit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(led_front_reg && led_rear_reg))
        else $error("both escape LEDs lit");

    // Timer is idle while cruising
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CRUISE) |-> (timer_reg == '0))
        else $error("timer running while cruising");

    // A held input beat is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled input beat lost");

    // Escape start loads the turn length
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_CRUISE && phase_next == PH_TURN)
            |=> (timer_reg == $past(turn_load)))
        else $error("turn timer not loaded at escape start");
`endif

endmodule

>>> bench/obstacle_escape_sequencer_core_tb.sv
// Self-checking bench for obstacle_escape_sequencer_core: drives sensor ticks and
// register writes, predicts each drive beat and checks it. Depends on oes_pkg.
`timescale 1ns / 100ps

module obstacle_escape_sequencer_core_tb;
    import oes_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 135;
    localparam int TAIL_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 8;
    localparam int SEQ_LEN      = 25;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Directed escape walk with near 100, clear 150, two-tick phases
    localparam logic [DIST_W-1:0] SEQ_FRONT [SEQ_LEN] = '{
        200, 99, 0, 200, 0, 0, 0, 0, 0, 0, 150, 0, 0,
        0, 0, 0, 0, 0, 255, 255, 255, 0, 0, 0, 255
    };
    localparam logic [DIST_W-1:0] SEQ_REAR [SEQ_LEN] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 255, 0, 150, 0, 151,
        0, 0, 0, 0, 100, 99, 0, 255, 0, 0, 0, 255
    };

    // Heading and escape origin encoding
    localparam logic GO_FWD = 1'b0;
    localparam logic GO_BWD = 1'b1;

    typedef enum logic [1:0] {CRUISING, TURNING, RUNNING, RETURNING} escape_phase_t;

    typedef struct packed {
        motor_cmd_t cmd;
        logic       led_front;
        logic       led_rear;
    } drive_beat_t;

    // Escape sequencer predictor plus queue of drive beats still owed
    class escape_scoreboard;
        logic [DIST_W-1:0]     near_lim   = NEAR_RST;
        logic [DIST_W-1:0]     clear_lim  = CLEAR_RST;
        logic [LEN_W-1:0]      turn_len   = TURN_RST;
        logic [LEN_W-1:0]      run_len    = RUN_RST;
        escape_phase_t         phase      = CRUISING;
        logic                  heading    = GO_FWD;
        logic                  origin     = GO_FWD;
        logic [TIMER_BITS-1:0] ticks_left = '0;
        drive_beat_t           drive_q[$];
        int                    errors     = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NEAR_CM:    near_lim  = data[DIST_W-1:0];
                REG_CLEAR_CM:   clear_lim = data[DIST_W-1:0];
                REG_TURN_TICKS: turn_len  = data[LEN_W-1:0];
                REG_RUN_TICKS:  run_len   = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // A zero length behaves as one tick
        function logic [TIMER_BITS-1:0] span(logic [LEN_W-1:0] len);
            return (len == '0) ? '0 : len - 1'b1;
        endfunction

        function motor_cmd_t travel_cmd();
            return (heading == GO_BWD) ? CMD_BWD : CMD_FWD;
        endfunction

        function motor_cmd_t swerve_cmd();
            return (origin == GO_BWD) ? CMD_LEFT : CMD_RIGHT;
        endfunction

        function motor_cmd_t return_cmd();
            return (heading == GO_BWD) ? CMD_RIGHT : CMD_LEFT;
        endfunction

        // Advance one tick and queue the drive beat it produces
        function void note_tick(logic [DIST_W-1:0] front, logic [DIST_W-1:0] rear);
            logic [DIST_W-1:0] ahead;
            logic [DIST_W-1:0] own;
            logic [DIST_W-1:0] other;
            drive_beat_t       beat;
            beat.cmd = CMD_FWD;
            case (phase)
                CRUISING:
                begin
                    ahead = (heading == GO_BWD) ? rear : front;
                    if (ahead < near_lim)
                    begin
                        origin     = heading;
                        phase      = TURNING;
                        ticks_left = span(turn_len);
                        beat.cmd   = swerve_cmd();
                    end
                    else
                    begin
                        beat.cmd = travel_cmd();
                    end
                end
                TURNING:
                begin
                    if (ticks_left != '0)
                    begin
                        ticks_left = ticks_left - 1'b1;
                        beat.cmd   = swerve_cmd();
                    end
                    else
                    begin
                        own   = (origin == GO_BWD) ? rear : front;
                        other = (origin == GO_BWD) ? front : rear;
                        if (own > clear_lim || other > clear_lim)
                        begin
                            // origin side wins when both are clear
                            heading    = (own > clear_lim) ? origin : ~origin;
                            phase      = RUNNING;
                            ticks_left = span(run_len);
                            beat.cmd   = travel_cmd();
                        end
                        else
                        begin
                            // boxed in: turn again the same way
                            ticks_left = span(turn_len);
                            beat.cmd   = swerve_cmd();
                        end
                    end
                end
                RUNNING:
                begin
                    if (ticks_left != '0)
                    begin
                        ticks_left = ticks_left - 1'b1;
                        beat.cmd   = travel_cmd();
                    end
                    else
                    begin
                        phase      = RETURNING;
                        ticks_left = span(turn_len);
                        beat.cmd   = return_cmd();
                    end
                end
                default:
                begin
                    if (ticks_left != '0)
                    begin
                        ticks_left = ticks_left - 1'b1;
                        beat.cmd   = return_cmd();
                    end
                    else
                    begin
                        phase      = CRUISING;
                        ticks_left = '0;
                        beat.cmd   = travel_cmd();
                    end
                end
            endcase
            beat.led_front = (phase != CRUISING) && (origin == GO_FWD);
            beat.led_rear  = (phase != CRUISING) && (origin == GO_BWD);
            drive_q.push_back(beat);
        endfunction

        // Compare one output beat against the oldest expected drive beat
        function void check_result(logic [M_DATA_W-1:0] data);
            drive_beat_t want;
            if (drive_q.size() == 0)
            begin
                $display("%0t: unexpected output beat, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            if (data[1:0] !== want.cmd)
            begin
                $display("%0t: motor_cmd expected %0d actual %0d", $time, want.cmd, data[1:0]);
                errors++;
            end
            if (data[2] !== want.led_front)
            begin
                $display("%0t: led_front expected %0b actual %0b", $time, want.led_front, data[2]);
                errors++;
            end
            if (data[3] !== want.led_rear)
            begin
                $display("%0t: led_rear expected %0b actual %0b", $time, want.led_rear, data[3]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  cfg_ready;

    escape_scoreboard sb;

    int  quiet_cycles = 0;
    int  rx_stall     = 0;
    int  rx_mode_left = 0;
    bit  rx_steady    = 1'b0;
    int  tx_mode_left = 0;
    bit  tx_steady    = 1'b0;

    obstacle_escape_sequencer_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Distance sample clustered around the current thresholds
    function automatic logic [DIST_W-1:0] pick_dist();
        int pick;
        int sample;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            sample = int'(sb.near_lim) + int'($urandom_range(0, 2)) - 1;
        else if (pick < 50)
            sample = int'(sb.clear_lim) + int'($urandom_range(0, 2)) - 1;
        else if (pick < 60)
            sample = 0;
        else if (pick < 70)
            sample = 255;
        else
            sample = $urandom_range(0, 255);
        if (sample < 0)
            sample = 0;
        if (sample > 255)
            sample = 255;
        return DIST_W'(sample);
    endfunction

    // Output side: check each accepted beat, then pick next cycle's tready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (rx_mode_left == 0)
        begin
            rx_steady    = ($urandom_range(0, 3) == 0);
            rx_mode_left = $urandom_range(20, 200);
        end
        else
        begin
            rx_mode_left--;
        end
        if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!rx_steady)
                rx_stall = idle_len();
        end
    end

    // Watchdog on cycles with no beat moving on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // One sensor tick beat; valid stays up across back-to-back beats
    task automatic send_tick(logic [DIST_W-1:0] front, logic [DIST_W-1:0] rear);
        int gap;
        if (tx_mode_left <= 0)
        begin
            tx_steady    = ($urandom_range(0, 3) == 0);
            tx_mode_left = $urandom_range(16, 128);
        end
        tx_mode_left--;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rear, front};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_tick(front, rear);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Stop sending, wait for every owed drive beat, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.drive_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Idle-time register update; upper data bits of the 8-bit registers are junk
    task automatic configure(logic [DIST_W-1:0] near, logic [DIST_W-1:0] clear,
                             logic [LEN_W-1:0] turn, logic [LEN_W-1:0] run);
        settle();
        write_reg(REG_NEAR_CM, {8'($urandom), near});
        write_reg(REG_CLEAR_CM, {8'($urandom), clear});
        write_reg(REG_TURN_TICKS, turn);
        write_reg(REG_RUN_TICKS, run);
        // unmapped index must be ignored
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_RUN_TICKS) + 1, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: exactly at near is no obstacle
        send_tick(8'd30, 8'd0);
        send_tick(8'd255, 8'd255);

        // Directed walk: own side clear, boxed in, other side clear, rear escape
        configure(8'd100, 8'd150, 16'd2, 16'd2);
        for (int i = 0; i < SEQ_LEN; i++)
            send_tick(SEQ_FRONT[i], SEQ_REAR[i]);

        // Random phases, extremes first, then small random lengths
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: configure(8'd0, 8'd0, 16'd1, 16'd1);
                1: configure(8'd255, 8'd255, 16'd0, 16'd0);
                2: configure(8'd255, 8'd0, 16'd0, 16'd0);
                default: configure(DIST_W'($urandom_range(20, 220)),
                                   DIST_W'($urandom_range(10, 240)),
                                   LEN_W'($urandom_range(0, 8)),
                                   LEN_W'($urandom_range(0, 12)));
            endcase
            repeat (PHASE_ITEMS) send_tick(pick_dist(), pick_dist());
        end

        // Longest phase lengths last, since a loaded timer cannot be cut short
        configure(8'd255, 8'd0, LEN_MAX, LEN_MAX);
        repeat (TAIL_ITEMS) send_tick(pick_dist(), pick_dist());

        s_axis_tvalid <= 1'b0;
        settle();
        if (sb.errors == 0 && sb.drive_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
